@@ rtl/lfs_pkg.sv @@
// ----------------------------------------------------------------------------
// lfs_pkg
// Shared widths, constants, cell control types and the letter filter.
// ----------------------------------------------------------------------------
package lfs_pkg;

  localparam int LETTER_W        = 8;
  localparam int LIMIT_W         = 6;
  localparam int MAX_LETTERS_DEF = 32;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(30);

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_SHIFT  = 2'd2
  } cell_op_t;

  typedef struct packed {
    cell_op_t              op;
    logic [LETTER_W-1:0]   code;
  } cell_ctl_t;

  // Letter codes: A-Z, a-z, and the two upper code blocks.
  function automatic logic is_letter(input logic [LETTER_W-1:0] c);
    logic r;
    r = (c >= 8'd65  && c <= 8'd90)  || (c >= 8'd97  && c <= 8'd122) ||
        (c >= 8'd128 && c <= 8'd175) || (c >= 8'd225 && c <= 8'd239);
    return r;
  endfunction

endpackage

@@ rtl/lfs_if.sv @@
// ----------------------------------------------------------------------------
// lfs_if
// Channel interfaces: input characters, sorted letters, configuration.
// ----------------------------------------------------------------------------
interface lfs_in_if;
  logic                          valid;
  logic                          ready;
  logic [lfs_pkg::LETTER_W-1:0]  char_code;
  logic                          char_present;
  logic                          last_char;

  modport source (output valid, char_code, char_present, last_char, input ready);
  modport sink   (input valid, char_code, char_present, last_char, output ready);
endinterface

interface lfs_out_if;
  logic                          valid;
  logic                          ready;
  logic [lfs_pkg::LETTER_W-1:0]  letter;
  logic                          last_letter;

  modport source (output valid, letter, last_letter, input ready);
  modport sink   (input valid, letter, last_letter, output ready);
endinterface

interface lfs_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [lfs_pkg::LIMIT_W-1:0]   data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ rtl/letter_filter_sorter.sv @@
// ----------------------------------------------------------------------------
// letter_filter_sorter
// Letter filter with an insertion-sorting cell chain and ordered drain.
// ----------------------------------------------------------------------------
// Takes one character word per cycle; letters are inserted into a chain of
// MAX_LETTERS cells in the same cycle, so input runs at full rate until the
// word marked last_char arrives. The stored letters then drain from the head
// of the chain, one per cycle unless the output is held off, and the input
// stays stalled after its last word until the last kept letter has left the chain.
// The output register lets a new string start while the final letter waits.
// The limit register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module letter_filter_sorter #(
  parameter int MAX_LETTERS = lfs_pkg::MAX_LETTERS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  lfs_in_if.sink     in_ch,
  lfs_out_if.source  out_ch,
  lfs_cfg_if.sink    cfg_ch
);

  localparam int CW   = $clog2(MAX_LETTERS + 1);
  localparam int CMPW = (CW > lfs_pkg::LIMIT_W) ? CW : lfs_pkg::LIMIT_W;

  logic [lfs_pkg::LIMIT_W-1:0]  limit_r;
  logic [CW-1:0]                count_r, count_nxt, count_ins;
  logic                         draining_r, draining_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [lfs_pkg::LETTER_W-1:0] out_letter_r;
  logic                         out_last_r;

  logic                         in_acc, ins, drain_go;
  logic [CMPW-1:0]              lim_eff;
  lfs_pkg::cell_ctl_t           ctl;

  logic [lfs_pkg::LETTER_W-1:0] val [MAX_LETTERS];
  logic                         gt  [MAX_LETTERS];
  logic                         occ [MAX_LETTERS];

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !draining_r;
  assign in_acc       = in_ch.valid && !draining_r;

  assign lim_eff = (CMPW'(limit_r) > CMPW'(MAX_LETTERS)) ? CMPW'(MAX_LETTERS)
                                                         : CMPW'(limit_r);

  assign ins = in_acc && in_ch.char_present && lfs_pkg::is_letter(in_ch.char_code)
               && (CMPW'(count_r) < lim_eff);

  assign drain_go = draining_r && (!out_valid_r || out_ch.ready);

  always_comb begin
    ctl.code = in_ch.char_code;
    if (drain_go) begin
      ctl.op = lfs_pkg::CELL_SHIFT;
    end else if (ins) begin
      ctl.op = lfs_pkg::CELL_INSERT;
    end else begin
      ctl.op = lfs_pkg::CELL_HOLD;
    end
  end

  generate
    for (genvar i = 0; i < MAX_LETTERS; i++) begin : g_cell
      assign occ[i] = (count_r > CW'(i));
      if (i == 0) begin : g_head
        lfs_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .left_val ('0),
          .left_gt  (1'b0),
          .left_occ (1'b1),
          .right_val(val[1]),
          .self_occ (occ[0]),
          .val      (val[0]),
          .gt       (gt[0])
        );
      end else if (i == MAX_LETTERS - 1) begin : g_tail
        lfs_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .left_val (val[i-1]),
          .left_gt  (gt[i-1]),
          .left_occ (occ[i-1] && !gt[i-1]),
          .right_val(val[i]),
          .self_occ (occ[i]),
          .val      (val[i]),
          .gt       (gt[i])
        );
      end else begin : g_mid
        lfs_cell u_cell (
          .clk      (clk),
          .ctl      (ctl),
          .left_val (val[i-1]),
          .left_gt  (gt[i-1]),
          .left_occ (occ[i-1] && !gt[i-1]),
          .right_val(val[i+1]),
          .self_occ (occ[i]),
          .val      (val[i]),
          .gt       (gt[i])
        );
      end
    end
  endgenerate

  always_comb begin
    count_ins     = ins ? (count_r + CW'(1)) : count_r;
    count_nxt     = count_r;
    draining_nxt  = draining_r;
    out_valid_nxt = (out_valid_r && !out_ch.ready) ? 1'b1 : 1'b0;
    if (drain_go) begin
      count_nxt     = count_r - CW'(1);
      out_valid_nxt = 1'b1;
      if (count_r == CW'(1)) begin
        draining_nxt = 1'b0;
      end
    end else if (in_acc) begin
      count_nxt = count_ins;
      // drain only when something was kept
      if (in_ch.last_char && (count_ins != '0)) begin
        draining_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r     <= lfs_pkg::LIMIT_RESET;
      count_r     <= '0;
      draining_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        limit_r <= cfg_ch.data;
      end
      count_r     <= count_nxt;
      draining_r  <= draining_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_go) begin
      out_letter_r <= val[0];
      out_last_r   <= (count_r == CW'(1));
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.letter      = out_letter_r;
  assign out_ch.last_letter = out_last_r;

endmodule

@@ rtl/lfs_cell.sv @@
// ----------------------------------------------------------------------------
// lfs_cell
// One slot of the sorting chain: holds one letter, inserts or shifts.
// ----------------------------------------------------------------------------
module lfs_cell (
  input  logic                          clk,
  input  lfs_pkg::cell_ctl_t            ctl,
  input  logic [lfs_pkg::LETTER_W-1:0]  left_val,
  input  logic                          left_gt,
  input  logic                          left_occ,
  input  logic [lfs_pkg::LETTER_W-1:0]  right_val,
  input  logic                          self_occ,
  output logic [lfs_pkg::LETTER_W-1:0]  val,
  output logic                          gt
);

  logic [lfs_pkg::LETTER_W-1:0] val_r;
  logic [lfs_pkg::LETTER_W-1:0] val_nxt;

  assign gt  = self_occ && (val_r > ctl.code);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    case (ctl.op)
      lfs_pkg::CELL_INSERT: begin
        // make room: take the left neighbour if it moves up, else take the new letter if it belongs here
        if (left_gt) begin
          val_nxt = left_val;
        end else if ((gt || !self_occ) && left_occ) begin
          val_nxt = ctl.code;
        end
      end
      lfs_pkg::CELL_SHIFT: val_nxt = right_val;
      default:             val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule
